// ===== rtl/narma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// narma_pkg: shared types and constants of the NARMA recurrence generator
// Fixed-point formats, register indexes, control word layout and the
// microprogram that sequences the shared multiplier.
// ----------------------------------------------------------------------------
package narma_pkg;

  localparam int ORDER    = 10;
  localparam int DATA_W   = 32;
  localparam int FRAC     = 24;
  localparam int WARM_W   = 16;
  localparam int WIN_W    = DATA_W + $clog2(ORDER);
  localparam int MUL_W    = DATA_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = WIN_W + MUL_W;
  localparam int CFG_IDX_W = 3;
  localparam int NSTEPS   = 12;
  localparam int STEP_W   = $clog2(NSTEPS);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [MUL_W-1:0]  THREE_HALVES = MUL_W'(25165824);

  localparam logic signed [DATA_W-1:0] COEF_A_RST = DATA_W'(5033165);
  localparam logic signed [DATA_W-1:0] COEF_B_RST = DATA_W'(838861);
  localparam logic signed [DATA_W-1:0] COEF_C_RST = DATA_W'(1677722);
  localparam logic signed [DATA_W-1:0] SCALE_RST  = DATA_W'(16777216);
  localparam logic [WARM_W-1:0]        WARMUP_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_A = 3'd0,
    CFG_COEF_B = 3'd1,
    CFG_COEF_C = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_WARMUP = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_U1_UN, MUL_Y1_WH, MUL_Y1_WL,
    MUL_Q_3H, MUL_A_Y1, MUL_B_P, MUL_SCALE_S
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOAD_SH, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_Q, WB_P, WB_T3, WB_T1, WB_T2, WB_S, WB_Y
  } wb_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
  } seq_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    wb_t      wb;
    seq_t     seq;
  } ctrl_t;

  // Microprogram. The multiplier result is registered, so an accumulator
  // action works on the product issued one step earlier, and a writeback
  // rounds the accumulator loaded one step earlier.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, wb: WB_NONE, seq: SEQ_NEXT};
    unique case (step)
      4'd0:  w = '{mul: MUL_U1_UN,   acc: ACC_HOLD,    wb: WB_NONE, seq: SEQ_WAIT_IN};
      4'd1:  w = '{mul: MUL_Y1_WH,   acc: ACC_LOAD,    wb: WB_NONE, seq: SEQ_NEXT};
      4'd2:  w = '{mul: MUL_Y1_WL,   acc: ACC_LOAD_SH, wb: WB_Q,    seq: SEQ_NEXT};
      4'd3:  w = '{mul: MUL_Q_3H,    acc: ACC_ADD,     wb: WB_NONE, seq: SEQ_NEXT};
      4'd4:  w = '{mul: MUL_A_Y1,    acc: ACC_LOAD,    wb: WB_P,    seq: SEQ_NEXT};
      4'd5:  w = '{mul: MUL_B_P,     acc: ACC_LOAD,    wb: WB_T3,   seq: SEQ_NEXT};
      4'd6:  w = '{mul: MUL_NONE,    acc: ACC_LOAD,    wb: WB_T1,   seq: SEQ_NEXT};
      4'd7:  w = '{mul: MUL_NONE,    acc: ACC_HOLD,    wb: WB_T2,   seq: SEQ_NEXT};
      4'd8:  w = '{mul: MUL_NONE,    acc: ACC_HOLD,    wb: WB_S,    seq: SEQ_NEXT};
      4'd9:  w = '{mul: MUL_SCALE_S, acc: ACC_HOLD,    wb: WB_NONE, seq: SEQ_NEXT};
      4'd10: w = '{mul: MUL_NONE,    acc: ACC_LOAD,    wb: WB_NONE, seq: SEQ_NEXT};
      4'd11: w = '{mul: MUL_NONE,    acc: ACC_HOLD,    wb: WB_Y,    seq: SEQ_WAIT_OUT};
      default: w = '{mul: MUL_NONE,  acc: ACC_HOLD,    wb: WB_NONE, seq: SEQ_WAIT_OUT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/narma_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// narma_if: valid/ready channels of the NARMA recurrence generator
// Input sample channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface narma_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [narma_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface narma_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [narma_pkg::DATA_W-1:0] value;
  logic                                in_warmup;

  modport source (output valid, output value, output in_warmup, input ready);
  modport sink   (input valid, input value, input in_warmup, output ready);
endinterface
`default_nettype wire

// ===== rtl/narma_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// narma_datapath: shared multiplier, accumulator and history of the generator
// Executes one control word per cycle: operand select, multiply, accumulate,
// round and saturate to Q8.24, and write back into the term registers.
// ----------------------------------------------------------------------------
module narma_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire narma_pkg::ctrl_t                       ctrl,
  input  wire logic                                   cfg_we,
  input  wire logic [narma_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [narma_pkg::DATA_W-1:0]           cfg_data,
  input  wire logic signed [narma_pkg::DATA_W-1:0]    u_in,
  output logic signed [narma_pkg::DATA_W-1:0]         y_out
);

  localparam int DW = narma_pkg::DATA_W;
  localparam int AW = narma_pkg::ACC_W;
  localparam int WW = narma_pkg::WIN_W;
  localparam int MW = narma_pkg::MUL_W;
  localparam int FR = narma_pkg::FRAC;
  localparam int ORD = narma_pkg::ORDER;

  function automatic logic signed [DW-1:0] sat_q(input logic signed [AW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > AW'(narma_pkg::Q_MAX)) begin
      r = narma_pkg::Q_MAX;
    end else if (v < AW'(narma_pkg::Q_MIN)) begin
      r = narma_pkg::Q_MIN;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic signed [DW-1:0] coef_a_r, coef_b_r, coef_c_r, scale_r;
  logic signed [DW-1:0] y_win_r [ORD];
  logic signed [DW-1:0] u_dly_r [ORD];
  logic signed [WW-1:0] win_sum_r;

  logic signed [MW-1:0] opa, opb;
  logic signed [narma_pkg::PROD_W-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] rnd_w, shr_w, sum_s;
  logic signed [DW-1:0] rs_q;
  logic signed [DW-1:0] q_r, p_r, t1_r, t2_r, t3_r, s_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= narma_pkg::COEF_A_RST;
      coef_b_r <= narma_pkg::COEF_B_RST;
      coef_c_r <= narma_pkg::COEF_C_RST;
      scale_r  <= narma_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        narma_pkg::CFG_COEF_A: coef_a_r <= cfg_data;
        narma_pkg::CFG_COEF_B: coef_b_r <= cfg_data;
        narma_pkg::CFG_COEF_C: coef_c_r <= cfg_data;
        narma_pkg::CFG_SCALE:  scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand select. The window sum is wider than one multiplier port, so it
  // goes through in two passes: the signed upper part and the low fraction.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctrl.mul)
      narma_pkg::MUL_U1_UN: begin
        opa = MW'(u_dly_r[0]);
        opb = MW'(u_dly_r[ORD-1]);
      end
      narma_pkg::MUL_Y1_WH: begin
        opa = MW'(y_win_r[0]);
        opb = MW'(signed'(win_sum_r[WW-1:FR]));
      end
      narma_pkg::MUL_Y1_WL: begin
        opa = MW'(y_win_r[0]);
        opb = {{(MW-FR){1'b0}}, win_sum_r[FR-1:0]};
      end
      narma_pkg::MUL_Q_3H: begin
        opa = MW'(q_r);
        opb = narma_pkg::THREE_HALVES;
      end
      narma_pkg::MUL_A_Y1: begin
        opa = MW'(coef_a_r);
        opb = MW'(y_win_r[0]);
      end
      narma_pkg::MUL_B_P: begin
        opa = MW'(coef_b_r);
        opb = MW'(p_r);
      end
      narma_pkg::MUL_SCALE_S: begin
        opa = MW'(scale_r);
        opb = MW'(s_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc)
      narma_pkg::ACC_LOAD:    acc_r <= AW'(prod_r);
      narma_pkg::ACC_LOAD_SH: acc_r <= AW'(prod_r) <<< FR;
      narma_pkg::ACC_ADD:     acc_r <= acc_r + AW'(prod_r);
      default: ;
    endcase
  end

  // Round half up to Q8.24, then saturate.
  assign rnd_w = acc_r + narma_pkg::ACC_HALF;
  assign shr_w = rnd_w >>> FR;
  assign rs_q  = sat_q(shr_w);
  assign sum_s = AW'(t1_r) + AW'(t2_r) + AW'(t3_r) + AW'(coef_c_r);
  assign y_out = rs_q;

  always_ff @(posedge clk) begin
    case (ctrl.wb)
      narma_pkg::WB_Q:  q_r  <= rs_q;
      narma_pkg::WB_P:  p_r  <= rs_q;
      narma_pkg::WB_T3: t3_r <= rs_q;
      narma_pkg::WB_T1: t1_r <= rs_q;
      narma_pkg::WB_T2: t2_r <= rs_q;
      narma_pkg::WB_S:  s_r  <= sat_q(sum_s);
      default: ;
    endcase
  end

  // Output and input history shift once per item, when the result is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORD; i++) begin
        y_win_r[i] <= '0;
        u_dly_r[i] <= '0;
      end
      win_sum_r <= '0;
    end else if (ctrl.wb == narma_pkg::WB_Y) begin
      y_win_r[0] <= rs_q;
      u_dly_r[0] <= u_in;
      for (int i = 1; i < ORD; i++) begin
        y_win_r[i] <= y_win_r[i-1];
        u_dly_r[i] <= u_dly_r[i-1];
      end
      win_sum_r <= win_sum_r - WW'(y_win_r[ORD-1]) + WW'(rs_q);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/narma_recurrence_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// narma_recurrence_generator_unit: NARMA recurrence generator, Q8.24
// Microcoded sequencer around one shared multiplier that produces one output
// sample of the nonlinear autoregressive recurrence per input sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on in_if (valid/ready); one beat carries one sample.
//   Each accepted beat produces exactly one result beat on out_if, carrying
//   the saturated Q8.24 output and a flag that marks the warmup items.
//   The configuration port writes one register per cycle while cfg_we is
//   high; it should only be used while no item is in flight.
// Timing:
//   A twelve-step microprogram drives a single 33 x 33 bit multiplier, and
//   the output feeds the next item, so items do not overlap. The result
//   beat becomes valid once the final step has written it into the output
//   register; the program then goes back to the step that takes input beats.
// Stalls:
//   A finished result sits in the output register until taken. The next item
//   is accepted and computed meanwhile; its final step holds until the output
//   register is free, so no result is lost or overwritten.
// Reset:
//   rst_n is synchronous and active low. It restores the register defaults,
//   clears the output and input history, the window sum and the item counter.
// ----------------------------------------------------------------------------
module narma_recurrence_generator_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  narma_in_if.sink                                  in_if,
  narma_out_if.source                               out_if,
  input  wire logic                                 cfg_we,
  input  wire logic [narma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [narma_pkg::DATA_W-1:0]         cfg_data
);

  localparam int DW = narma_pkg::DATA_W;
  localparam int SW = narma_pkg::STEP_W;

  // Step counter and the control word it selects from the microprogram.
  logic [SW-1:0]     step_r, step_nxt;
  narma_pkg::ctrl_t  ctrl, ctrl_eff;
  logic              in_fire, out_free, adv, y_fire;

  // Warmup bookkeeping and the captured sample of the item in flight.
  logic [narma_pkg::WARM_W-1:0] warmup_r, seen_r;
  logic                         warm_now;
  logic signed [DW-1:0]         u_r;
  logic                         warm_r;

  // Output register.
  logic                 out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic                 out_warm_r;
  logic signed [DW-1:0] y_val;

  assign ctrl = narma_pkg::ucode(step_r);

  assign in_if.ready = (ctrl.seq == narma_pkg::SEQ_WAIT_IN);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // A step advances unless it waits for an input beat or for room in the
  // output register.
  always_comb begin
    case (ctrl.seq)
      narma_pkg::SEQ_WAIT_IN:  adv = in_fire;
      narma_pkg::SEQ_WAIT_OUT: adv = out_free;
      default:                 adv = 1'b1;
    endcase
  end

  // A held step must not write back, otherwise the history would shift
  // more than once for the same item.
  always_comb begin
    ctrl_eff = ctrl;
    if (!adv) begin
      ctrl_eff.wb = narma_pkg::WB_NONE;
    end
  end

  assign y_fire = (ctrl_eff.wb == narma_pkg::WB_Y);

  // The final step jumps back to the start of the program.
  always_comb begin
    step_nxt = step_r;
    if (adv) begin
      if (ctrl.seq == narma_pkg::SEQ_WAIT_OUT) begin
        step_nxt = '0;
      end else begin
        step_nxt = step_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // The warmup count is compared against the saturating item counter.
  assign warm_now = (seen_r < warmup_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= narma_pkg::WARMUP_RST;
    end else if (cfg_we && (cfg_index == narma_pkg::CFG_WARMUP)) begin
      warmup_r <= cfg_data[narma_pkg::WARM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (in_fire && (seen_r != '1)) begin
      seen_r <= seen_r + narma_pkg::WARM_W'(1);
    end
  end

  // During warmup the sample is replaced by zero before it enters history.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      u_r    <= warm_now ? '0 : in_if.sample;
      warm_r <= warm_now;
    end
  end

  narma_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl_eff),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .u_in      (u_r),
    .y_out     (y_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (y_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (y_fire) begin
      out_value_r <= y_val;
      out_warm_r  <= warm_r;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.value     = out_value_r;
  assign out_if.in_warmup = out_warm_r;

  // A result is only written into a free output register.
  a_wb_room: assert property (@(posedge clk) disable iff (!rst_n)
    y_fire |-> out_free)
    else $error("result written while output register is occupied");

  // One item at a time: right after an input beat no other is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("input accepted while an item is still in flight");

  // A written result shows up as a valid beat in the next cycle.
  a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
    y_fire |=> out_if.valid)
    else $error("finished result did not reach the output");

  // The step counter never leaves the microprogram.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < SW'(narma_pkg::NSTEPS))
    else $error("step counter outside the microprogram");

endmodule
`default_nettype wire
